### rtl/cpr_pkg.sv
// Shared types and constants for the clock page replacement block.
`default_nettype none

package cpr_pkg;

  // Widths of the fixed result fields.
  localparam int PAGE_W = 16;
  localparam int SLOT_W = 3;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_page;   // capture the page of an accepted transfer, restart the scan
    logic scan_issue;  // read the tag store at the scan counter
    logic ev_issue;    // read the tag store at the clock hand
    logic hit_done;    // record a hit on the frame just compared
    logic sweep_step;  // clear the use bit under the hand and advance the hand
    logic place;       // put the page in the frame under the hand
    logic evict;       // with place: the frame held a resident page
    logic load_out;    // move the finished result to the output register
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic cnt_end;     // every frame has had its tag read
    logic hit;         // the tag just read matches a valid frame
    logic scan_miss;   // the last frame has been compared without a match
    logic hand_valid;  // frame under the hand is valid
    logic hand_use;    // frame under the hand has its use bit set
    logic out_free;    // the output register can take a result this cycle
  } sts_t;

endpackage

`default_nettype wire

### rtl/clock_page_replacement.sv
// A hit ends the scan at the matching frame; a miss scans all FRAMES tags through the one
// read port, then sweeps one frame per cycle. One item at a time: the next input transfer
// can be taken in the cycle after the result is loaded. A waiting result does not block the
// next input transfer. Reset clears the valid and use bits, the hand and the control state;
// tags are not cleared.
`default_nettype none

module clock_page_replacement #(
  parameter int FRAMES    = 8,
  parameter int PAGE_BITS = 16
) (
  input  wire                         clk,
  input  wire                         rst,
  input  wire                         in_valid,
  output logic                        in_ready,
  input  wire [cpr_pkg::PAGE_W-1:0]   page_number,
  output logic                        out_valid,
  input  wire                         out_ready,
  output logic                        fault,
  output logic [cpr_pkg::SLOT_W-1:0]  frame_index,
  output logic                        evicted_valid,
  output logic [cpr_pkg::PAGE_W-1:0]  evicted_page
);

  cpr_pkg::cmd_t cmd;
  cpr_pkg::sts_t sts;

  cpr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  cpr_datapath #(
    .FRAMES    (FRAMES),
    .PAGE_BITS (PAGE_BITS)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .sts           (sts),
    .page_number   (page_number),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .fault         (fault),
    .frame_index   (frame_index),
    .evicted_valid (evicted_valid),
    .evicted_page  (evicted_page)
  );

endmodule

`default_nettype wire

### rtl/cpr_ctrl.sv
// Controller state machine for the clock page replacement block.
`default_nettype none

module cpr_ctrl (
  input  wire              clk,
  input  wire              rst,
  input  wire              in_valid,
  output logic             in_ready,
  input  cpr_pkg::sts_t    sts,
  output cpr_pkg::cmd_t    cmd
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SCAN  = 3'd1;
  localparam logic [2:0] S_SWEEP = 3'd2;
  localparam logic [2:0] S_EVICT = 3'd3;
  localparam logic [2:0] S_DONE  = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_page = 1'b1;
          state_next    = S_SCAN;
        end
      end
      S_SCAN: begin
        // Reads run one frame ahead of the compare.
        cmd.scan_issue = !sts.cnt_end;
        if (sts.hit) begin
          cmd.hit_done = 1'b1;
          state_next   = S_DONE;
        end else if (sts.scan_miss) begin
          state_next = S_SWEEP;
        end
      end
      S_SWEEP: begin
        if (!sts.hand_valid) begin
          cmd.place  = 1'b1;
          state_next = S_DONE;
        end else if (sts.hand_use) begin
          cmd.sweep_step = 1'b1;
        end else begin
          cmd.ev_issue = 1'b1;
          state_next   = S_EVICT;
        end
      end
      S_EVICT: begin
        cmd.place  = 1'b1;
        cmd.evict  = 1'b1;
        state_next = S_DONE;
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

### rtl/cpr_datapath.sv
// Datapath of the clock page replacement block: tag store, frame bits, hand, result registers.
`default_nettype none

module cpr_datapath #(
  parameter int FRAMES    = 8,
  parameter int PAGE_BITS = 16
) (
  input  wire                           clk,
  input  wire                           rst,
  input  cpr_pkg::cmd_t                 cmd,
  output cpr_pkg::sts_t                 sts,
  input  wire [cpr_pkg::PAGE_W-1:0]     page_number,
  output logic                          out_valid,
  input  wire                           out_ready,
  output logic                          fault,
  output logic [cpr_pkg::SLOT_W-1:0]    frame_index,
  output logic                          evicted_valid,
  output logic [cpr_pkg::PAGE_W-1:0]    evicted_page
);

  localparam int IDX_W = $clog2(FRAMES);

  logic [PAGE_BITS-1:0] tags [FRAMES];
  logic [PAGE_BITS-1:0] rdata;
  logic [PAGE_BITS-1:0] page;
  logic [IDX_W:0]       cnt;
  logic [IDX_W-1:0]     rd_idx;
  logic                 rd_live;
  logic [IDX_W-1:0]     hand;
  logic [IDX_W-1:0]     hand_next;
  logic [IDX_W-1:0]     rd_addr;
  logic [FRAMES-1:0]    valid_bits;
  logic [FRAMES-1:0]    use_bits;
  logic                 hit;

  logic                 res_fault;
  logic [IDX_W-1:0]     res_slot;
  logic                 res_ev_valid;
  logic [PAGE_BITS-1:0] res_ev_page;

  logic [PAGE_BITS+cpr_pkg::PAGE_W-1:0] page_ext;
  logic [PAGE_BITS+cpr_pkg::PAGE_W-1:0] ev_ext;
  logic [IDX_W+cpr_pkg::SLOT_W-1:0]     slot_ext;

  assign page_ext  = {{PAGE_BITS{1'b0}}, page_number};
  assign ev_ext    = {{cpr_pkg::PAGE_W{1'b0}}, res_ev_page};
  assign slot_ext  = {{cpr_pkg::SLOT_W{1'b0}}, res_slot};
  assign hand_next = (hand == IDX_W'(FRAMES - 1)) ? '0 : hand + 1'b1;
  assign rd_addr   = cmd.ev_issue ? hand : cnt[IDX_W-1:0];
  assign hit       = rd_live && valid_bits[rd_idx] && (rdata == page);

  always_comb begin
    sts            = '0;
    sts.cnt_end    = (cnt == (IDX_W + 1)'(FRAMES));
    sts.hit        = hit;
    sts.scan_miss  = rd_live && (rd_idx == IDX_W'(FRAMES - 1)) && !hit;
    sts.hand_valid = valid_bits[hand];
    sts.hand_use   = use_bits[hand];
    sts.out_free   = !out_valid || out_ready;
  end

  // Tag store: one write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (cmd.place) begin
      tags[hand] <= page;
    end
    if (cmd.scan_issue || cmd.ev_issue) begin
      rdata <= tags[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_bits <= '0;
      use_bits   <= '0;
      hand       <= '0;
      rd_live    <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      rd_live <= cmd.scan_issue;
      if (cmd.hit_done) begin
        use_bits[rd_idx] <= 1'b1;
      end
      if (cmd.sweep_step) begin
        use_bits[hand] <= 1'b0;
        hand           <= hand_next;
      end
      if (cmd.place) begin
        valid_bits[hand] <= 1'b1;
        use_bits[hand]   <= 1'b1;
        hand             <= hand_next;
      end
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_page) begin
      page <= page_ext[PAGE_BITS-1:0];
      cnt  <= '0;
    end else if (cmd.scan_issue) begin
      cnt <= cnt + 1'b1;
    end
    if (cmd.scan_issue) begin
      rd_idx <= cnt[IDX_W-1:0];
    end
    if (cmd.hit_done) begin
      res_fault    <= 1'b0;
      res_slot     <= rd_idx;
      res_ev_valid <= 1'b0;
      res_ev_page  <= '0;
    end else if (cmd.place) begin
      res_fault    <= 1'b1;
      res_slot     <= hand;
      res_ev_valid <= cmd.evict;
      res_ev_page  <= cmd.evict ? rdata : '0;
    end
    if (cmd.load_out) begin
      fault         <= res_fault;
      frame_index   <= slot_ext[cpr_pkg::SLOT_W-1:0];
      evicted_valid <= res_ev_valid;
      evicted_page  <= ev_ext[cpr_pkg::PAGE_W-1:0];
    end
  end

`ifndef NO_ASSERTIONS
  // A placed frame is valid and marked used afterwards.
  assert property (@(posedge clk) disable iff (rst)
    cmd.place |=> valid_bits[$past(hand)] && use_bits[$past(hand)])
    else $error("placed frame not valid and used");

  // The hand moves only when the sweep steps or a page is placed.
  assert property (@(posedge clk) disable iff (rst)
    !cmd.place && !cmd.sweep_step |=> $stable(hand))
    else $error("clock hand moved without a sweep step or placement");

  // A sweep step gives the frame its second chance by clearing its use bit.
  assert property (@(posedge clk) disable iff (rst)
    cmd.sweep_step |=> !use_bits[$past(hand)])
    else $error("sweep step left the use bit set");

  // Eviction only ever reads a frame that is valid and not recently used.
  assert property (@(posedge clk) disable iff (rst)
    cmd.ev_issue |-> valid_bits[hand] && !use_bits[hand])
    else $error("eviction chosen on an empty or used frame");
`endif

endmodule

`default_nettype wire
